/* src/ihv_pkg.sv */
`timescale 1ns / 1ps

package ihv_pkg;

  // Defaults for the top level parameters
  localparam int unsigned MAX_DIMENSION_DEF = 2048;
  localparam int unsigned LENGTH_BITS_DEF   = 24;

  // Fixed field widths
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned DIM_W  = 32;
  localparam int unsigned KIND_W = 2;

  // Verdict limits
  localparam int unsigned    MIN_SIZE    = 16;
  localparam int unsigned    MAX_SIZE    = 8 * 1024 * 1024;
  localparam logic [63:0]    MAX_PIXELS  = 64'd4 * 64'd1024 * 64'd1024;
  localparam int unsigned    PNG_HDR_LEN = 24;

  // Result queue depth between parser and verdict stages (power of two)
  localparam int unsigned FIFO_DEPTH = 2;

  // Byte codes
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] JPEG_SOI = 8'hD8;
  localparam logic [7:0] JPEG_EOI = 8'hD9;
  localparam logic [7:0] SOF_LO   = 8'hC0;
  localparam logic [7:0] SOF_HI   = 8'hCF;
  localparam logic [7:0] DHT      = 8'hC4;
  localparam logic [7:0] JPG_RSV  = 8'hC8;
  localparam logic [7:0] DAC      = 8'hCC;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_PNG  = 2'd1,
    KIND_JPEG = 2'd2
  } kind_e;

  // JPEG segment walker phases, one-hot
  typedef enum logic [5:0] {
    PH_SEEK   = 6'b000001,
    PH_MARKER = 6'b000010,
    PH_LEN_HI = 6'b000100,
    PH_LEN_LO = 6'b001000,
    PH_SOF    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  total_length;
  } in_item_t;

  typedef struct packed {
    logic              image_ok;
    logic [KIND_W-1:0] image_kind;
    logic [DIM_W-1:0]  pixel_width;
    logic [DIM_W-1:0]  pixel_height;
  } out_item_t;

  // Per-file record handed from parser to verdict stage
  typedef struct packed {
    kind_e            kind;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } rec_t;

  function automatic logic [7:0] png_sig_byte(input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = 8'h89;
      2'd1:    r = 8'h50;
      2'd2:    r = 8'h4E;
      default: r = 8'h47;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ihdr_byte(input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = 8'h49;
      2'd1:    r = 8'h48;
      2'd2:    r = 8'h44;
      default: r = 8'h52;
    endcase
    return r;
  endfunction

  function automatic logic is_sof(input logic [7:0] m);
    return (m >= SOF_LO) && (m <= SOF_HI) && (m != DHT) && (m != JPG_RSV) && (m != DAC);
  endfunction

endpackage

/* src/ihv_stream_if.sv */
`timescale 1ns / 1ps

interface ihv_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/ihv_front.sv */
`timescale 1ns / 1ps

module ihv_front #(
  parameter int unsigned LENGTH_BITS = ihv_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ihv_stream_if.sink    in_i,
  output logic          rec_push_o,
  output ihv_pkg::rec_t rec_o,
  input  logic          rec_full_i
);

  logic [LENGTH_BITS-1:0] idx_q, idx_d, mp_q, mp_d, len, sof_off;
  logic [LENGTH_BITS:0]   len_ext, idx_inc, mp_plus9, mp_seg_end;
  logic                   png_q, png_d, jst_q, jst_d, png_now, jst_now;
  logic [7:0]             prior_q, prior_d, marker_q, marker_d, b;
  logic [15:0]            seg_q, seg_d, seg_full;
  logic [31:0]            fw_q, fw_d, fh_q, fh_d;
  ihv_pkg::phase_e        phase_q, phase_d;
  logic                   acc, last, size_ok, is_jpeg;

  assign b       = in_i.payload.data_byte;
  assign len     = LENGTH_BITS'(in_i.payload.total_length);
  assign len_ext = {1'b0, len};
  assign idx_inc = {1'b0, idx_q} + (LENGTH_BITS+1)'(1);
  assign last    = idx_inc >= len_ext;

  assign in_i.ready = !rec_full_i;
  assign acc        = in_i.valid && in_i.ready;

  assign mp_plus9   = {1'b0, mp_q} + (LENGTH_BITS+1)'(9);
  assign seg_full   = seg_q | {8'h00, b};
  assign mp_seg_end = {1'b0, mp_q} + (LENGTH_BITS+1)'(2) + (LENGTH_BITS+1)'(seg_full);
  assign sof_off    = idx_q - mp_q;

  // signature checks fold in the current byte
  always_comb begin
    png_now = png_q;
    jst_now = jst_q;
    if (idx_q < LENGTH_BITS'(4) && b != ihv_pkg::png_sig_byte(idx_q[1:0])) begin
      png_now = 1'b0;
    end
    if (idx_q >= LENGTH_BITS'(12) && idx_q < LENGTH_BITS'(16)
        && b != ihv_pkg::ihdr_byte(idx_q[1:0])) begin
      png_now = 1'b0;
    end
    if (idx_q == LENGTH_BITS'(0) && b != ihv_pkg::BYTE_FF) begin
      jst_now = 1'b0;
    end
    if (idx_q == LENGTH_BITS'(1) && b != ihv_pkg::JPEG_SOI) begin
      jst_now = 1'b0;
    end
  end

  // header capture and JPEG segment walk
  always_comb begin
    mp_d     = mp_q;
    seg_d    = seg_q;
    marker_d = marker_q;
    fw_d     = fw_q;
    fh_d     = fh_q;
    phase_d  = phase_q;
    if (png_now) begin
      if (idx_q >= LENGTH_BITS'(16) && idx_q < LENGTH_BITS'(20)) begin
        fw_d = {fw_q[23:0], b};
      end else if (idx_q >= LENGTH_BITS'(20) && idx_q < LENGTH_BITS'(24)) begin
        fh_d = {fh_q[23:0], b};
      end
    end else if (jst_now && idx_q >= LENGTH_BITS'(2)) begin
      case (phase_q)
        ihv_pkg::PH_SEEK: begin
          if (idx_q == mp_q) begin
            if (!jst_now || mp_plus9 >= len_ext) begin
              phase_d = ihv_pkg::PH_DONE;
            end else if (b != ihv_pkg::BYTE_FF) begin
              mp_d = mp_q + LENGTH_BITS'(1);
            end else begin
              phase_d = ihv_pkg::PH_MARKER;
            end
          end
        end
        ihv_pkg::PH_MARKER: begin
          if (b == ihv_pkg::JPEG_SOI || b == ihv_pkg::JPEG_EOI) begin
            mp_d    = mp_q + LENGTH_BITS'(2);
            phase_d = ihv_pkg::PH_SEEK;
          end else begin
            marker_d = b;
            phase_d  = ihv_pkg::PH_LEN_HI;
          end
        end
        ihv_pkg::PH_LEN_HI: begin
          seg_d   = {b, 8'h00};
          phase_d = ihv_pkg::PH_LEN_LO;
        end
        ihv_pkg::PH_LEN_LO: begin
          seg_d = seg_full;
          if (seg_full < 16'd2 || mp_seg_end > len_ext) begin
            phase_d = ihv_pkg::PH_DONE;
          end else if (ihv_pkg::is_sof(marker_q)) begin
            phase_d = ihv_pkg::PH_SOF;
          end else begin
            mp_d    = mp_seg_end[LENGTH_BITS-1:0];
            phase_d = ihv_pkg::PH_SEEK;
          end
        end
        ihv_pkg::PH_SOF: begin
          if (sof_off == LENGTH_BITS'(5) || sof_off == LENGTH_BITS'(6)) begin
            fh_d = {16'h0000, fh_q[7:0], b};
          end else if (sof_off == LENGTH_BITS'(7) || sof_off == LENGTH_BITS'(8)) begin
            fw_d = {16'h0000, fw_q[7:0], b};
          end
          if (sof_off >= LENGTH_BITS'(8)) begin
            phase_d = ihv_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-file record on the last byte
  assign size_ok = len >= LENGTH_BITS'(ihv_pkg::MIN_SIZE)
                && len <= LENGTH_BITS'(ihv_pkg::MAX_SIZE);
  assign is_jpeg = !png_now && jst_now && prior_q == ihv_pkg::BYTE_FF
                && b == ihv_pkg::JPEG_EOI;

  always_comb begin
    rec_o.kind   = ihv_pkg::KIND_NONE;
    rec_o.width  = '0;
    rec_o.height = '0;
    if (size_ok) begin
      if (png_now) begin
        rec_o.kind = ihv_pkg::KIND_PNG;
        if (len >= LENGTH_BITS'(ihv_pkg::PNG_HDR_LEN)) begin
          rec_o.width  = fw_d;
          rec_o.height = fh_d;
        end
      end else if (is_jpeg) begin
        rec_o.kind   = ihv_pkg::KIND_JPEG;
        rec_o.width  = fw_d;
        rec_o.height = fh_d;
      end
    end
  end

  assign rec_push_o = acc && last;

  always_comb begin
    idx_d   = idx_q;
    prior_d = prior_q;
    png_d   = png_q;
    jst_d   = jst_q;
    if (acc && !last) begin
      idx_d   = idx_inc[LENGTH_BITS-1:0];
      prior_d = b;
      png_d   = png_now;
      jst_d   = jst_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      png_q    <= 1'b1;
      jst_q    <= 1'b1;
      prior_q  <= '0;
      phase_q  <= ihv_pkg::PH_SEEK;
      mp_q     <= LENGTH_BITS'(2);
      seg_q    <= '0;
      marker_q <= '0;
      fw_q     <= '0;
      fh_q     <= '0;
    end else if (acc && last) begin
      idx_q    <= '0;
      png_q    <= 1'b1;
      jst_q    <= 1'b1;
      prior_q  <= '0;
      phase_q  <= ihv_pkg::PH_SEEK;
      mp_q     <= LENGTH_BITS'(2);
      seg_q    <= '0;
      marker_q <= '0;
      fw_q     <= '0;
      fh_q     <= '0;
    end else if (acc) begin
      idx_q    <= idx_d;
      png_q    <= png_d;
      jst_q    <= jst_d;
      prior_q  <= prior_d;
      phase_q  <= phase_d;
      mp_q     <= mp_d;
      seg_q    <= seg_d;
      marker_q <= marker_d;
      fw_q     <= fw_d;
      fh_q     <= fh_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push_o |-> !rec_full_i)
    else $error("record pushed into full queue");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !last) |=> idx_q == LENGTH_BITS'($past(idx_q) + LENGTH_BITS'(1)))
    else $error("byte index did not advance");

  a_png_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    png_q |-> (phase_q == ihv_pkg::PH_SEEK && mp_q == LENGTH_BITS'(2)))
    else $error("JPEG walker moved while PNG signature still matches");

endmodule

/* src/ihv_fifo.sv */
`timescale 1ns / 1ps

module ihv_fifo #(
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  valid_o
);

  localparam int unsigned Depth   = ihv_pkg::FIFO_DEPTH;
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;

  item_t              mem_q [Depth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == (PtrBits+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PtrBits+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PtrBits+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* src/ihv_back.sv */
`timescale 1ns / 1ps

module ihv_back #(
  parameter int unsigned MAX_DIMENSION = ihv_pkg::MAX_DIMENSION_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ihv_pkg::rec_t rec_i,
  input  logic          rec_valid_i,
  output logic          rec_pop_o,
  ihv_stream_if.source  out_o
);

  localparam int unsigned DimBits  = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned ProdBits = 2 * DimBits;

  logic                      a_valid_q, out_valid_q, a_ready, b_adv, b_load;
  ihv_pkg::rec_t             a_rec_q;
  logic                      a_dims_ok_q, dims_ok;
  logic [ProdBits-1:0]       a_prod_q;
  ihv_pkg::out_item_t        out_q;

  assign b_adv     = !out_valid_q || out_o.ready;
  assign a_ready   = !a_valid_q || b_adv;
  assign rec_pop_o = rec_valid_i && a_ready;
  assign b_load    = a_valid_q && b_adv;

  assign dims_ok = rec_i.width != '0 && rec_i.height != '0
                && rec_i.width <= ihv_pkg::DIM_W'(MAX_DIMENSION)
                && rec_i.height <= ihv_pkg::DIM_W'(MAX_DIMENSION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= rec_valid_i;
      end
      if (b_adv) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  // stage A: range checks and pixel product, stage B: pixel limit
  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      a_rec_q     <= rec_i;
      a_dims_ok_q <= dims_ok;
      a_prod_q    <= ProdBits'(rec_i.width[DimBits-1:0]) * ProdBits'(rec_i.height[DimBits-1:0]);
    end
    if (b_load) begin
      out_q.image_ok     <= a_dims_ok_q && (64'(a_prod_q) <= ihv_pkg::MAX_PIXELS);
      out_q.image_kind   <= a_rec_q.kind;
      out_q.pixel_width  <= a_rec_q.width;
      out_q.pixel_height <= a_rec_q.height;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_ok_has_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.image_ok)
      |-> out_o.payload.image_kind != ihv_pkg::KIND_NONE)
    else $error("pass verdict without a recognized format");

  a_prod_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_dims_ok_q)
      |-> 64'(a_prod_q) <= 64'(MAX_DIMENSION) * 64'(MAX_DIMENSION))
    else $error("pixel product beyond dimension limit");

  a_a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_adv) |=> a_valid_q)
    else $error("stage A dropped a record while output stalled");

endmodule

/* src/image_header_validator_top.sv */
`timescale 1ns / 1ps

// Image header validator.
// in_i  : one transaction per file byte, payload {data_byte, total_length};
//         total_length is repeated on every byte of a file.
// out_o : one transaction per file, issued for its last byte, payload
//         {image_ok, image_kind, pixel_width, pixel_height}.
// The last byte of a file is the one whose index plus one reaches
// total_length; the parser then clears itself for the next file.
// Throughput: one byte per cycle while the record queue has room, sustained,
// in back-to-back files too. The edge that takes the last byte writes the
// record queue; the check stage and then the output register load it in turn.
// The parser updates its state once per accepted byte; the pixel
// multiply and limit compare sit in the two-stage check pipeline.
// Reset (rst_ni low, asynchronous) empties the queue and pipeline and
// puts the parser at byte zero with the PNG and JPEG signature checks open.
// A stalled out_o is absorbed by the output register, the check stage and
// a two-entry record queue; only when the queue is full does in_i.ready
// drop, which then holds off further bytes.
module image_header_validator_top #(
  parameter int unsigned MAX_DIMENSION = ihv_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned LENGTH_BITS   = ihv_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ihv_stream_if.sink   in_i,
  ihv_stream_if.source out_o
);

  // parser -> queue
  logic          push, full;
  ihv_pkg::rec_t push_rec;
  // queue -> verdict stage
  logic          pop, q_valid;
  ihv_pkg::rec_t q_rec;

  ihv_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .rec_push_o (push),
    .rec_o      (push_rec),
    .rec_full_i (full)
  );

  ihv_fifo #(
    .item_t (ihv_pkg::rec_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_rec),
    .valid_o (q_valid)
  );

  ihv_back #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (q_rec),
    .rec_valid_i (q_valid),
    .rec_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule
